>>> rtl/core/rabp_pkg.sv
// ----------------------------------------------------------------------------
// rabp_pkg
// Shared constants and types of the running autocorrelation beat period block.
// ----------------------------------------------------------------------------
`default_nettype none

package rabp_pkg;

  // Lag geometry
  localparam int unsigned HistDepth    = 2048;
  localparam int unsigned MinLag       = 200;
  localparam int unsigned MaxLag       = 2000;
  localparam int unsigned SearchMaxLag = 1000;

  localparam int unsigned LagCount    = MaxLag - MinLag + 1;
  localparam int unsigned SearchTop   = (SearchMaxLag < MaxLag) ? SearchMaxLag : MaxLag;
  localparam int unsigned SearchCount = SearchTop - MinLag + 1;

  localparam int unsigned HistAw = $clog2(HistDepth);
  localparam int unsigned AccAw  = $clog2(LagCount);

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned LagW    = 10;
  localparam int unsigned AccW    = 48;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = AccW + CfgW;

  // Configuration register map
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegCheckInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDecayInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDecayFactor   = 2'd2;

  localparam logic [CfgW-1:0] CheckIntervalRst = 16'd43;
  localparam logic [CfgW-1:0] DecayIntervalRst = 16'd30;
  localparam logic [CfgW-1:0] DecayFactorRst   = 16'd64225;

  // Operation carried down the sweep pipeline
  typedef enum logic [1:0] {
    OP_ACC  = 2'd0,
    OP_SRCH = 2'd1,
    OP_DEC  = 2'd2
  } op_e;

  typedef struct packed {
    logic [CfgW-1:0] check_interval;
    logic [CfgW-1:0] decay_interval;
    logic [CfgW-1:0] decay_factor;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [SampleW-1:0] sample;
    logic               block_end;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [LagW-1:0] lag;
    logic [AccW-1:0] value;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/rabp_ram.sv
// ----------------------------------------------------------------------------
// rabp_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rabp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/rabp_engine.sv
// ----------------------------------------------------------------------------
// rabp_engine
// Sweep sequencer and datapath over the history ring and lag accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module rabp_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rabp_pkg::cfg_t cfg_i,
  input  wire rabp_pkg::item_t item_i,
  input  wire logic           out_free_i,
  output logic                busy_o,
  output rabp_pkg::res_t      res_o
);

  import rabp_pkg::*;

  localparam int unsigned KW = HistAw;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ACC   = 7'b0000100,
    ST_SRCH  = 7'b0001000,
    ST_DEC   = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [KW-1:0]      k_q, k_d;
  logic [HistAw-1:0]  wp_q, wp_d;
  logic [CfgW-1:0]    chk_q, chk_d;
  logic [CfgW-1:0]    dec_q, dec_d;
  logic               do_search_q, do_search_d;
  logic               do_decay_q, do_decay_d;
  op_e                last_q, last_d;
  logic [SampleW-1:0] sample_q;
  logic               end_q;

  logic issue;
  op_e  issue_op;
  logic best_clr;
  logic emit;
  logic clr_acc_we;

  logic               hist_we;
  logic [HistAw-1:0]  hist_waddr;
  logic [SampleW-1:0] hist_wdata;
  logic [HistAw-1:0]  hist_raddr;
  logic [SampleW-1:0] hist_rdata;

  logic              acc_we;
  logic [AccAw-1:0]  acc_waddr;
  logic [AccW-1:0]   acc_wdata;
  logic [AccW-1:0]   acc_rdata;

  logic              s1_valid_q, s2_valid_q;
  op_e               s1_op_q, s2_op_q;
  logic [AccAw-1:0]  s1_k_q, s2_k_q;
  logic [ProdW-1:0]  prod_q;
  logic [AccW-1:0]   acc1_q;
  logic [AccW-1:0]   best_val_q;
  logic [AccAw-1:0]  best_k_q;

  logic [AccW-1:0]   mul_a;
  logic [CfgW-1:0]   mul_b;
  logic [ProdW-1:0]  mul_p;
  logic [AccW:0]     acc_sum;
  logic [AccW-1:0]   acc_sat;

  logic [HistAw-1:0] lag_w;
  logic [HistAw:0]   idx_wrap;
  logic [HistAw-1:0] wp_inc;
  logic [CfgW:0]     chk_inc, dec_inc;
  logic              chk_fire, dec_fire;
  logic [KW-1:0]     peak_lag_full;

  // Ring position of the sample lag_w items back
  always_comb begin
    lag_w    = HistAw'(MinLag) + HistAw'(k_q);
    idx_wrap = (HistAw+1)'(wp_q) + (HistAw+1)'(HistDepth) - (HistAw+1)'(lag_w);
    if (wp_q >= lag_w) begin
      hist_raddr = wp_q - lag_w;
    end else begin
      hist_raddr = idx_wrap[HistAw-1:0];
    end
    wp_inc = (wp_q == HistAw'(HistDepth - 1)) ? '0 : wp_q + 1'b1;
  end

  always_comb begin
    chk_inc  = (CfgW+1)'(chk_q) + (CfgW+1)'(1);
    dec_inc  = (CfgW+1)'(dec_q) + (CfgW+1)'(1);
    chk_fire = chk_inc > (CfgW+1)'(cfg_i.check_interval);
    dec_fire = dec_inc > (CfgW+1)'(cfg_i.decay_interval);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    wp_d        = wp_q;
    chk_d       = chk_q;
    dec_d       = dec_q;
    do_search_d = do_search_q;
    do_decay_d  = do_decay_q;
    last_d      = last_q;
    issue       = 1'b0;
    issue_op    = OP_ACC;
    best_clr    = 1'b0;
    emit        = 1'b0;
    clr_acc_we  = 1'b0;
    hist_we     = 1'b0;
    hist_waddr  = wp_q;
    hist_wdata  = item_i.sample;

    unique case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = k_q[HistAw-1:0];
        hist_wdata = '0;
        clr_acc_we = (k_q < KW'(LagCount));
        if (k_q == KW'(HistDepth - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (item_i.start) begin
          hist_we = 1'b1;
          k_d     = '0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        issue    = 1'b1;
        issue_op = OP_ACC;
        if (k_q == KW'(LagCount - 1)) begin
          k_d         = '0;
          wp_d        = wp_inc;
          do_search_d = 1'b0;
          do_decay_d  = 1'b0;
          if (end_q) begin
            chk_d       = chk_fire ? '0 : chk_inc[CfgW-1:0];
            dec_d       = dec_fire ? '0 : dec_inc[CfgW-1:0];
            do_search_d = chk_fire;
            do_decay_d  = dec_fire;
          end
          last_d  = OP_ACC;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_SRCH: begin
        issue    = 1'b1;
        issue_op = OP_SRCH;
        if (k_q == KW'(SearchCount - 1)) begin
          k_d     = '0;
          last_d  = OP_SRCH;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DEC: begin
        issue    = 1'b1;
        issue_op = OP_DEC;
        if (k_q == KW'(LagCount - 1)) begin
          k_d     = '0;
          last_d  = OP_DEC;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Wait for the last write-back before the next sweep
        if (!s1_valid_q && !s2_valid_q) begin
          case (last_q)
            OP_ACC: begin
              if (do_search_q) begin
                best_clr = 1'b1;
                state_d  = ST_SRCH;
              end else if (do_decay_q) begin
                state_d = ST_DEC;
              end else begin
                state_d = ST_IDLE;
              end
            end
            OP_SRCH: state_d = ST_EMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit    = 1'b1;
          state_d = do_decay_q ? ST_DEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      wp_q        <= '0;
      chk_q       <= '0;
      dec_q       <= '0;
      do_search_q <= 1'b0;
      do_decay_q  <= 1'b0;
      last_q      <= OP_ACC;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      wp_q        <= wp_d;
      chk_q       <= chk_d;
      dec_q       <= dec_d;
      do_search_q <= do_search_d;
      do_decay_q  <= do_decay_d;
      last_q      <= last_d;
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q && (s1_op_q != OP_SRCH);
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && item_i.start) begin
      sample_q <= item_i.sample;
      end_q    <= item_i.block_end;
    end
  end

  // Stage 1: memory data back, multiply or compare
  always_comb begin
    if (s1_op_q == OP_ACC) begin
      mul_a = AccW'(hist_rdata);
      mul_b = CfgW'(sample_q);
    end else begin
      mul_a = acc_rdata;
      mul_b = cfg_i.decay_factor;
    end
    mul_p = ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= issue_op;
    s1_k_q  <= k_q[AccAw-1:0];
    s2_op_q <= s1_op_q;
    s2_k_q  <= s1_k_q;
    prod_q  <= mul_p;
    acc1_q  <= acc_rdata;
  end

  // Strict greater-than keeps the first maximum
  always_ff @(posedge clk_i) begin
    if (best_clr) begin
      best_val_q <= '0;
      best_k_q   <= '0;
    end else if (s1_valid_q && (s1_op_q == OP_SRCH) && (acc_rdata > best_val_q)) begin
      best_val_q <= acc_rdata;
      best_k_q   <= s1_k_q;
    end
  end

  // Stage 2: saturating add or scaled value, write back
  always_comb begin
    acc_sum = (AccW+1)'(acc1_q) + (AccW+1)'(prod_q[AccW-1:0]);
    acc_sat = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    acc_we  = clr_acc_we || s2_valid_q;
    if (clr_acc_we) begin
      acc_waddr = k_q[AccAw-1:0];
      acc_wdata = '0;
    end else begin
      acc_waddr = s2_k_q;
      acc_wdata = (s2_op_q == OP_ACC) ? acc_sat : prod_q[AccW+FracW-1:FracW];
    end
  end

  rabp_ram #(
    .Width (SampleW),
    .Depth (HistDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  rabp_ram #(
    .Width (AccW),
    .Depth (LagCount)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (k_q[AccAw-1:0]),
    .rdata_o (acc_rdata)
  );

  assign peak_lag_full = KW'(MinLag) + KW'(best_k_q);
  assign busy_o        = (state_q != ST_IDLE);
  assign res_o.valid   = emit;
  assign res_o.lag     = peak_lag_full[LagW-1:0];
  assign res_o.value   = best_val_q;

endmodule

`default_nettype wire

>>> rtl/core/running_autocorrelation_beat_period.sv
// ----------------------------------------------------------------------------
// running_autocorrelation_beat_period
// Tempo estimator: running autocorrelation of an envelope stream with peak
// reports and periodic decay.
// ----------------------------------------------------------------------------
// After reset the block clears the history ring and the lag accumulators
// and holds in_stall_o high meanwhile. Each sample is then processed one
// accumulator per cycle over the 1801 lags, bounded by the single read port
// of each memory, followed by the pipeline drain. A block end that triggers
// a peak report adds a search over lags 200..1000 and the hand-over of the
// result, which waits for a free output register; a block end that triggers
// a decay adds another sweep over all lags. A report waiting in the output
// register does not stop the next sample from being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module running_autocorrelation_beat_period (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rabp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rabp_pkg::CfgW-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [rabp_pkg::SampleW-1:0]    sample_i,
  input  wire logic                            block_end_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [rabp_pkg::LagW-1:0]       peak_lag_o,
  output logic      [rabp_pkg::AccW-1:0]       peak_value_o
);

  import rabp_pkg::*;

  cfg_t            cfg_q;
  item_t           item;
  res_t            res;
  logic            busy;
  logic            out_free;
  logic            out_valid_q;
  logic [LagW-1:0] peak_lag_q;
  logic [AccW-1:0] peak_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_interval <= CheckIntervalRst;
      cfg_q.decay_interval <= DecayIntervalRst;
      cfg_q.decay_factor   <= DecayFactorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCheckInterval: cfg_q.check_interval <= cfg_wdata_i;
        RegDecayInterval: cfg_q.decay_interval <= cfg_wdata_i;
        RegDecayFactor:   cfg_q.decay_factor   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o      = busy;
  assign item.start      = in_valid_i && !busy;
  assign item.sample     = sample_i;
  assign item.block_end  = block_end_i;

  assign out_free = !out_valid_q || !out_stall_i;

  rabp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item),
    .out_free_i (out_free),
    .busy_o     (busy),
    .res_o      (res)
  );

  // Hold the report until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      peak_lag_q   <= res.lag;
      peak_value_q <= res.value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_lag_o   = peak_lag_q;
  assign peak_value_o = peak_value_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives envelope samples into the beat period estimator and compares every
// peak report against a cycle-free model of the lag accumulators, with random
// stalls on both channels, a long output hold-off and configuration changes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rabp_pkg::*;

  // One sample sweep, a peak search and a decay sweep, rounded up
  localparam int SettleCycles = 4500;
  localparam int HoldCycles   = 20000;
  localparam int QuietLimit   = 100000;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic [63:0] AccMax = (64'd1 << AccW) - 64'd1;

  typedef struct {
    logic [LagW-1:0] lag;
    logic [AccW-1:0] value;
  } peak_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [SampleW-1:0]   sample_i    = '0;
  logic                 block_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LagW-1:0]      peak_lag_o;
  logic [AccW-1:0]      peak_value_o;

  // Model state
  logic [SampleW-1:0] hist_ring [HistDepth];
  logic [AccW-1:0]    lag_acc [LagCount];
  int unsigned        ring_wr;
  int unsigned        blocks_since_report;
  int unsigned        blocks_since_decay;
  cfg_t               model_cfg;
  peak_t              expected_peaks [$];
  int                 peaks_predicted = 0;

  int fail_count   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  running_autocorrelation_beat_period dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .block_end_i (block_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .peak_lag_o  (peak_lag_o),
    .peak_value_o(peak_value_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- model

  task automatic clear_model();
    for (int i = 0; i < HistDepth; i++) hist_ring[i] = '0;
    for (int k = 0; k < LagCount; k++) lag_acc[k] = '0;
    ring_wr             = 0;
    blocks_since_report = 0;
    blocks_since_decay  = 0;
    model_cfg.check_interval = CheckIntervalRst;
    model_cfg.decay_interval = DecayIntervalRst;
    model_cfg.decay_factor   = DecayFactorRst;
  endtask

  task automatic correlate_sample(input logic [SampleW-1:0] s, input logic be);
    logic [63:0]     prod;
    logic [63:0]     sum;
    int unsigned     back;
    int unsigned     best_k;
    logic [AccW-1:0] best;
    peak_t           pk;
    hist_ring[ring_wr] = s;
    for (int k = 0; k < LagCount; k++) begin
      back = (ring_wr + HistDepth - ((MinLag + k) % HistDepth)) % HistDepth;
      prod = 64'(s) * 64'(hist_ring[back]);
      sum  = 64'(lag_acc[k]) + prod;
      lag_acc[k] = (sum > AccMax) ? AccMax[AccW-1:0] : sum[AccW-1:0];
    end
    ring_wr = (ring_wr + 1) % HistDepth;
    if (be) begin
      blocks_since_report++;
      if (blocks_since_report > model_cfg.check_interval) begin
        // strict compare: the lowest lag wins a tie, lag MinLag if all zero
        best_k = 0;
        best   = '0;
        for (int lag = MinLag; lag <= SearchTop; lag++) begin
          if (lag_acc[lag - MinLag] > best) begin
            best   = lag_acc[lag - MinLag];
            best_k = lag - MinLag;
          end
        end
        pk.lag   = LagW'(MinLag + best_k);
        pk.value = best;
        expected_peaks.push_back(pk);
        peaks_predicted++;
        blocks_since_report = 0;
      end
      blocks_since_decay++;
      if (blocks_since_decay > model_cfg.decay_interval) begin
        for (int k = 0; k < LagCount; k++)
          lag_acc[k] = AccW'((64'(lag_acc[k]) * 64'(model_cfg.decay_factor)) >> FracW);
        blocks_since_decay = 0;
      end
    end
  endtask

  // ------------------------------------------------------------ monitors

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) correlate_sample(sample_i, block_end_i);
  end

  always @(posedge clk_i) begin : check_peaks
    peak_t pk;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_peaks.size() == 0) begin
        $error("unexpected peak report: lag %0d value %0d", peak_lag_o, peak_value_o);
        fail_count++;
      end else begin
        pk = expected_peaks.pop_front();
        if (peak_lag_o !== pk.lag) begin
          $error("peak_lag: expected %0d, got %0d", pk.lag, peak_lag_o);
          fail_count++;
        end
        if (peak_value_o !== pk.value) begin
          $error("peak_value: expected %0d, got %0d", pk.value, peak_value_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------- drivers

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegCheckInterval: model_cfg.check_interval = val;
      RegDecayInterval: model_cfg.decay_interval = val;
      RegDecayFactor:   model_cfg.decay_factor   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CfgW-1:0] chk, input logic [CfgW-1:0] dec,
                            input logic [CfgW-1:0] factor);
    write_reg(RegCheckInterval, chk);
    write_reg(RegDecayInterval, dec);
    write_reg(RegDecayFactor, factor);
  endtask

  // Valid stays high after acceptance so back-to-back items need no second
  // assignment in the same step; lower it only before a gap.
  task automatic send_item(input logic [SampleW-1:0] s, input logic be);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 20 * tx_idle_pct);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    block_end_i <= be;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Drop valid, wait for every pending report, then let the block go idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(3))
      0:       return SampleW'($urandom_range(0, 255));
      1:       return SampleW'(16'hFFFF - $urandom_range(0, 255));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic pick_config(input bit frequent_reports);
    logic [CfgW-1:0] chk;
    logic [CfgW-1:0] dec;
    logic [CfgW-1:0] factor;
    case ($urandom_range(7))
      0:       chk = 16'hFFFF;
      1:       chk = CfgW'($urandom_range(3, 12));
      default: chk = CfgW'($urandom_range(0, 2));
    endcase
    if (frequent_reports) chk = CfgW'($urandom_range(0, 1));
    case ($urandom_range(5))
      0:       dec = 16'hFFFF;
      1:       dec = '0;
      default: dec = CfgW'($urandom_range(1, 6));
    endcase
    case ($urandom_range(5))
      0:       factor = '0;
      1:       factor = 16'hFFFF;
      2:       factor = DecayFactorRst;
      default: factor = CfgW'($urandom);
    endcase
    set_config(chk, dec, factor);
  endtask

  // --------------------------------------------------------------- tests

  // History still empty at these lags: every report is lag MinLag, value 0
  task automatic test_empty_history();
    set_config(16'd0, 16'hFFFF, 16'hFFFF);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b1);
    send_item(16'h0001, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    drain();
  endtask

  // Lower the report interval below a counter that has run past it
  task automatic test_interval_lowered();
    set_config(16'hFFFF, 16'hFFFF, DecayFactorRst);
    repeat (4) send_item(pick_sample(), 1'b1);
    drain();
    write_reg(RegCheckInterval, 16'd2);
    send_item(pick_sample(), 1'b1);
    send_item(pick_sample(), 1'b0);
    drain();
  endtask

  task automatic test_unknown_register();
    write_reg(RegSpare, CfgW'($urandom));
    set_config(16'd0, 16'd0, 16'd0);
    repeat (3) send_item(pick_sample(), 1'b1);
    drain();
  endtask

  task automatic test_random(input int segments, input int seg_len, input int min_reports);
    int sent;
    bit extend;
    for (int seg = 0; seg < segments; seg++) begin
      extend = (seg == segments - 1) && (min_reports > 0);
      pick_config(extend);
      sent = 0;
      while (sent < seg_len || (extend && peaks_predicted < min_reports)) begin
        send_item(pick_sample(), $urandom_range(99) < 35);
        sent++;
      end
      drain();
    end
  endtask

  // Hold the output off so reports pile up and the input stalls
  task automatic test_output_hold();
    set_config(16'd0, 16'hFFFF, DecayFactorRst);
    hold_req = HoldCycles;
    repeat (8) send_item(pick_sample(), 1'b1);
    drain();
  endtask

  task automatic test_decay_extremes();
    set_config(16'd0, 16'd0, 16'hFFFF);
    repeat (3) send_item(pick_sample(), 1'b1);
    drain();
    write_reg(RegDecayFactor, 16'd1);
    repeat (2) send_item(pick_sample(), 1'b1);
    drain();
    write_reg(RegDecayFactor, 16'd0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b1);
    drain();
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct  = 15;
    rx_stall_pct = 69;
    test_empty_history();
    test_interval_lowered();
    test_unknown_register();
    test_random(3, 30, 0);

    tx_idle_pct  = 69;
    rx_stall_pct = 15;
    test_random(3, 30, 0);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random(3, 30, 48);
    test_output_hold();
    test_decay_extremes();

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
